// ===== rtl/yuv420_to_rgb_converter_top_assert.svh =====
// Assertion macros for the checker of the YUV 4:2:0 to RGB converter.
// Depends on nothing; the including scope must provide clock and reset.
`ifndef YUV420_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define YUV420_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Concurrent check, inactive while reset is high.
`define YUVRGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define YUVRGB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/yuvrgb_pkg.sv =====
// Package for the YUV 4:2:0 to RGB converter: sizes, types, coefficients, helpers.
// No dependencies.
package yuvrgb_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int CHROMA_DEPTH = MAX_WIDTH / 2;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int SLOT_W       = $clog2(CHROMA_DEPTH);
   localparam int CFG_W        = 13;
   localparam int CHROMA_W     = 16;
   localparam int RESET_WIDTH  = 1920;

   // Q2.16 color coefficients
   localparam logic signed [17:0] COEF_RV = 18'sd91881;
   localparam logic signed [17:0] COEF_GU = 18'sd22544;
   localparam logic signed [17:0] COEF_GV = 18'sd46793;
   localparam logic signed [17:0] COEF_BU = 18'sd116130;

   typedef logic [CFG_W-1:0]        cfg_data_type;
   typedef logic [7:0]              sample_type;
   typedef logic [CHROMA_W-1:0]     chroma_type;
   typedef logic [COL_W-1:0]        column_type;
   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic signed [8:0]       centered_type;
   typedef logic signed [26:0]      product_type;
   typedef logic signed [10:0]      term_type;

   // Even, at least 2, at most MAX_WIDTH.
   function automatic cfg_data_type eff_width(cfg_data_type w);
      cfg_data_type e;
      e = {w[CFG_W-1:1], 1'b0};
      if (e < cfg_data_type'(2)) begin
         e = cfg_data_type'(2);
      end
      if (int'(e) > MAX_WIDTH) begin
         e = cfg_data_type'(MAX_WIDTH & ~1);
      end
      return e;
   endfunction

   // Divide by 2^16, rounding toward zero.
   function automatic term_type trunc_q16(product_type p);
      product_type adj;
      adj = p[26] ? (p + product_type'(65535)) : p;
      return term_type'(adj >>> 16);
   endfunction

   function automatic sample_type clamp8(term_type v);
      sample_type r;
      if (v < term_type'(0)) begin
         r = 8'd0;
      end else if (v > term_type'(255)) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/yuvrgb_req_if.sv =====
// Request channel of the converter: one luma pixel with its chroma pair.
// Depends on yuvrgb_pkg.
interface yuvrgb_req_if;
   import yuvrgb_pkg::*;

   logic       valid;
   logic       ready;
   sample_type luma;
   sample_type cb_sample;
   sample_type cr_sample;
   logic       frame_start;

   modport source (output valid, luma, cb_sample, cr_sample, frame_start, input ready);
   modport sink   (input valid, luma, cb_sample, cr_sample, frame_start, output ready);
endinterface

// ===== rtl/yuvrgb_rsp_if.sv =====
// Response channel of the converter: one RGB pixel.
// Depends on yuvrgb_pkg.
interface yuvrgb_rsp_if;
   import yuvrgb_pkg::*;

   logic       valid;
   logic       ready;
   sample_type red;
   sample_type green;
   sample_type blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/yuvrgb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module yuvrgb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/yuv420_to_rgb_converter_top.sv =====
// Pipeline from request accept to response valid: 3 register stages (line RAM read /
// products / sum-truncate-clamp). Throughput: one request per cycle; a stalled response
// backs up into req.ready. Reset (synchronous): clears position, held chroma, pipeline
// valids; width = 1920. The chroma line RAM is not cleared; the user must make odd rows
// read only slots the prior even row wrote, which the block itself does not enforce.
// Depends on yuvrgb_pkg, yuvrgb_req_if, yuvrgb_rsp_if, yuvrgb_ram.
module yuv420_to_rgb_converter_top (
   input  logic                      clock,
   input  logic                      reset,
   yuvrgb_req_if.sink                req,
   yuvrgb_rsp_if.source              rsp,
   input  logic                      csr_wr_en,
   input  yuvrgb_pkg::cfg_data_type  csr_wr_data
);
   import yuvrgb_pkg::*;

   // ---------------------------------------------------------------
   // Configuration: the effective (even, saturated) width is stored,
   // so the wrap compare sees a clean value.
   // ---------------------------------------------------------------
   cfg_data_type width_ff, width_in;

   assign width_in = csr_wr_en ? eff_width(csr_wr_data) : width_ff;

   // ---------------------------------------------------------------
   // Pipeline handshake. Each stage moves when the next is empty or
   // moving; req.ready follows rsp.ready through this chain.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, rsp_valid_ff;
   logic adv1, adv2, adv3;
   logic accept;

   assign adv3      = !rsp_valid_ff || rsp.ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req.ready = adv1;
   assign accept    = req.valid && adv1;

   // ---------------------------------------------------------------
   // Stage 0: raster position, chroma hold and line buffer access.
   // A request with frame_start sees row 0, column 0.
   // ---------------------------------------------------------------
   column_type   col_ff, col_in, col_eff;
   logic         odd_ff, odd_in, odd_eff;
   chroma_type   held_ff, held_in;
   chroma_type   req_chroma;
   cfg_data_type col_next;
   logic         even_col_even_row;
   slot_type     slot;

   assign col_eff           = req.frame_start ? '0 : col_ff;
   assign odd_eff           = req.frame_start ? 1'b0 : odd_ff;
   assign req_chroma        = {req.cb_sample, req.cr_sample};
   assign even_col_even_row = !odd_eff && !col_eff[0];
   assign slot              = col_eff[COL_W-1:1];
   assign col_next          = cfg_data_type'(col_eff) + cfg_data_type'(1);

   always_comb begin
      col_in  = col_ff;
      odd_in  = odd_ff;
      held_in = held_ff;
      if (accept) begin
         // wrap at (or past, after a width change) the line end
         if (col_next >= width_ff) begin
            col_in = '0;
            odd_in = !odd_eff;
         end else begin
            col_in = col_next[COL_W-1:0];
            odd_in = odd_eff;
         end
         if (even_col_even_row) begin
            held_in = req_chroma;
         end
      end
   end

   // Line buffer: even rows write the pair at column/2, odd rows read it.
   // A slot is written at least two requests before the next row reads it,
   // so write and read of one entry never meet in a cycle.
   chroma_type ram_rd_data;

   yuvrgb_ram #(
      .WIDTH (CHROMA_W),
      .DEPTH (CHROMA_DEPTH)
   ) u_chroma_line (
      .clock   (clock),
      .wr_en   (accept && even_col_even_row),
      .wr_addr (slot),
      .wr_data (req_chroma),
      .rd_en   (accept && odd_eff),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   // Stage 1 registers; RAM output holds while the stage stalls since
   // a new read only comes with a new accept.
   sample_type luma1_ff;
   logic       odd1_ff;
   chroma_type chroma1_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         luma1_ff   <= req.luma;
         odd1_ff    <= odd_eff;
         chroma1_ff <= even_col_even_row ? req_chroma : held_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1 -> 2: center chroma, form the four products.
   // ---------------------------------------------------------------
   chroma_type   chroma_s1;
   centered_type u_s1, v_s1;
   product_type  prv_in, pgu_in, pgv_in, pbu_in;

   assign chroma_s1 = odd1_ff ? ram_rd_data : chroma1_ff;
   assign u_s1      = $signed({1'b0, chroma_s1[15:8]}) - 9'sd128;
   assign v_s1      = $signed({1'b0, chroma_s1[7:0]}) - 9'sd128;
   assign prv_in    = product_type'(COEF_RV) * product_type'(v_s1);
   assign pgu_in    = product_type'(COEF_GU) * product_type'(u_s1);
   assign pgv_in    = product_type'(COEF_GV) * product_type'(v_s1);
   assign pbu_in    = product_type'(COEF_BU) * product_type'(u_s1);

   sample_type  luma2_ff;
   product_type prv_ff, pgu_ff, pgv_ff, pbu_ff;

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         luma2_ff <= luma1_ff;
         prv_ff   <= prv_in;
         pgu_ff   <= pgu_in;
         pgv_ff   <= pgv_in;
         pbu_ff   <= pbu_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2 -> 3: truncate toward zero, add luma, clamp.
   // Green truncates the sum of its two products once.
   // ---------------------------------------------------------------
   term_type   y_s2;
   sample_type red_in, green_in, blue_in;

   assign y_s2     = $signed({3'b000, luma2_ff});
   assign red_in   = clamp8(y_s2 + trunc_q16(prv_ff));
   assign green_in = clamp8(y_s2 - trunc_q16(pgu_ff + pgv_ff));
   assign blue_in  = clamp8(y_s2 + trunc_q16(pbu_ff));

   sample_type red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   logic v1_in, v2_in, rsp_valid_in;

   assign v1_in        = adv1 ? req.valid : v1_ff;
   assign v2_in        = adv2 ? v1_ff : v2_ff;
   assign rsp_valid_in = adv3 ? v2_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= cfg_data_type'(RESET_WIDTH);
         col_ff       <= '0;
         odd_ff       <= 1'b0;
         held_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         col_ff       <= col_in;
         odd_ff       <= odd_in;
         held_ff      <= held_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;
endmodule

// ===== rtl/yuvrgb_checker.sv =====
// Port-level checker for yuv420_to_rgb_converter_top, attached by bind.
// Depends on yuv420_to_rgb_converter_top_assert.svh.
`include "yuv420_to_rgb_converter_top_assert.svh"

module yuvrgb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] red,
   input logic [7:0] green,
   input logic [7:0] blue
);
   logic req_accept;

   assign req_accept = req_valid && req_ready;

   `YUVRGB_ASSERT_RST(a_reset_empties, reset |=> !rsp_valid, "response valid after reset")

   `YUVRGB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(red) && $stable(green) && $stable(blue), "stalled response changed")

   `YUVRGB_ASSERT(a_ready_free, !rsp_valid || rsp_ready |-> req_ready, "request stalled with free output")

   `YUVRGB_ASSERT(a_latency, $past(req_accept, 3) && $past(!reset, 1) && $past(!reset, 2) && $past(rsp_ready, 1) && $past(rsp_ready, 2) |-> rsp_valid, "response missing 3 cycles after request")
endmodule

bind yuv420_to_rgb_converter_top yuvrgb_checker u_yuvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .red       (rsp.red),
   .green     (rsp.green),
   .blue      (rsp.blue)
);

// ===== bench/tb_yuv420_to_rgb_converter_top.sv =====
// Self-checking bench for yuv420_to_rgb_converter_top: drives 4:2:0 pixel requests,
// predicts each RGB response in-bench and compares it field by field, in order.
// Depends on yuvrgb_pkg, yuvrgb_req_if, yuvrgb_rsp_if and the converter RTL.
`timescale 1ns / 1ps

module tb_yuv420_to_rgb_converter_top;
   import yuvrgb_pkg::*;

   // Q2.16 color weights, BT.601 style
   localparam int RED_FROM_CR   = 91881;
   localparam int GREEN_FROM_CB = 22544;
   localparam int GREEN_FROM_CR = 46793;
   localparam int BLUE_FROM_CB  = 116130;

   localparam int LATENCY     = 3;     // spare wait before a width write and at the end
   localparam int STALL_LIMIT = 1000;  // cycles with no handshake on either side
   localparam int HOLD_CYCLES = 120;   // long response back-pressure

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
   } rgb_pixel_type;

   typedef struct {
      sample_type    luma;
      sample_type    cb;
      sample_type    cr;
      logic          fs;
      bit            typed;   // expected value given below instead of predicted
      rgb_pixel_type rgb;
   } pixel_row_type;

   typedef struct {
      cfg_data_type width;
      int           count;
      int           fs_permille;
   } phase_type;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   cfg_data_type csr_wr_data;

   yuvrgb_req_if req_ch ();
   yuvrgb_rsp_if rsp_ch ();

   yuv420_to_rgb_converter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Predicted converter state: raster position, latched chroma pair and
   // the chroma line. line_written marks slots an even row has filled, so
   // odd rows never get steered onto a slot that holds nothing yet.
   // ------------------------------------------------------------------
   int unsigned  pos_column = 0;
   bit           pos_odd_row = 1'b0;
   chroma_type   held_pair = '0;
   cfg_data_type width_reg = cfg_data_type'(RESET_WIDTH);
   chroma_type   line_store [CHROMA_DEPTH];
   bit           line_written [CHROMA_DEPTH];

   rgb_pixel_type expected_pixels [$];

   int error_count    = 0;
   int pixels_sent    = 0;
   int pixels_checked = 0;
   int widths_used    = 1;
   int stall_cycles   = 0;
   bit src_burst      = 1'b0;
   bit sink_burst     = 1'b0;
   bit held_off       = 1'b0;

   // Width actually used: bit 0 dropped, then held inside 2..MAX_WIDTH.
   function automatic int unsigned active_width(cfg_data_type w);
      int unsigned e;
      e = int'(w) & ~1;
      if (e < 2) begin
         e = 2;
      end
      if (e > MAX_WIDTH) begin
         e = MAX_WIDTH;
      end
      return e;
   endfunction

   function automatic sample_type saturate_byte(int v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return sample_type'(v);
   endfunction

   // Advance the predicted state by one pixel and return its RGB value.
   // SV integer division rounds toward zero, as the datapath truncates.
   function automatic rgb_pixel_type convert_pixel(sample_type y, sample_type cb,
                                                   sample_type cr, logic fs);
      int unsigned   span;
      int unsigned   slot;
      chroma_type    pair;
      int            u;
      int            v;
      rgb_pixel_type px;
      span = active_width(width_reg);
      if (fs) begin
         pos_column  = 0;
         pos_odd_row = 1'b0;
      end
      slot = (pos_column >> 1) % CHROMA_DEPTH;
      if (pos_odd_row) begin
         pair = line_store[slot];
      end else begin
         if (pos_column % 2 == 0) begin
            held_pair          = {cb, cr};
            line_store[slot]   = held_pair;
            line_written[slot] = 1'b1;
         end
         pair = held_pair;
      end
      u = int'(pair[15:8]) - 128;
      v = int'(pair[7:0]) - 128;
      px.red   = saturate_byte(int'(y) + (RED_FROM_CR * v) / 65536);
      px.green = saturate_byte(int'(y) - (GREEN_FROM_CB * u + GREEN_FROM_CR * v) / 65536);
      px.blue  = saturate_byte(int'(y) + (BLUE_FROM_CB * u) / 65536);
      pos_column++;
      if (pos_column >= span) begin
         pos_column  = 0;
         pos_odd_row = ~pos_odd_row;
      end
      return px;
   endfunction

   // Sample values biased toward the extremes and neutral chroma.
   function automatic sample_type pick_sample();
      unique case ($urandom_range(0, 15))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd128;
         default: return sample_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Request side. Each call starts at a falling edge so valid is never
   // lowered and raised in the same step between back-to-back requests.
   // ------------------------------------------------------------------
   task automatic send_pixel(sample_type y, sample_type cb, sample_type cr, logic fs,
                             bit typed, rgb_pixel_type typed_rgb);
      int            gap;
      rgb_pixel_type px;
      if ($urandom_range(0, 47) == 0) begin
         src_burst = ~src_burst;
      end
      gap = src_burst ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.luma        <= y;
      req_ch.cb_sample   <= cb;
      req_ch.cr_sample   <= cr;
      req_ch.frame_start <= fs;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      px = convert_pixel(y, cb, cr, fs);
      expected_pixels.push_back(typed ? typed_rgb : px);
      pixels_sent++;
   endtask

   // Drop valid and wait until every outstanding response is back.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_line_width(cfg_data_type w);
      settle();
      repeat (LATENCY) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      width_reg = w;
      widths_used++;
   endtask

   // Raster-order pixels with random content. Frame starts are rare; one is
   // forced when the next pixel would sit on an odd row over an empty slot.
   task automatic run_pixels(int count, int fs_permille);
      sample_type y;
      sample_type cb;
      sample_type cr;
      logic       fs;
      for (int i = 0; i < count; i++) begin
         y  = pick_sample();
         cb = pick_sample();
         cr = pick_sample();
         fs = ($urandom_range(0, 999) < fs_permille);
         if (pos_odd_row && !line_written[(pos_column >> 1) % CHROMA_DEPTH]) begin
            fs = 1'b1;
         end
         send_pixel(y, cb, cr, fs, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table, run at a programmed width of 3 (used as 2), so rows
   // alternate parity every two pixels. Typed rows are neutral chroma or
   // all-zero chroma; the rest go through the predictor.
   // ------------------------------------------------------------------
   pixel_row_type directed_rows [22] = '{
      '{8'd0,   8'd128, 8'd128, 1'b1, 1'b1, '{8'd0,   8'd0,   8'd0  }},  // frame start
      '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, '{8'd255, 8'd255, 8'd255}},  // odd col reuses pair
      '{8'd128, 8'd0,   8'd255, 1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}},  // odd row: from line
      '{8'd17,  8'd255, 8'd0,   1'b0, 1'b1, '{8'd17,  8'd17,  8'd17 }},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, '{8'd0,   8'd135, 8'd0  }},  // most negative chroma
      '{8'd255, 8'd128, 8'd128, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd0,   8'd128, 8'd128, 1'b0, 1'b1, '{8'd0,   8'd135, 8'd0  }},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},  // most positive chroma
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd128, 8'd255, 8'd0,   1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd128, 8'd0,   8'd255, 1'b1, 1'b0, '{8'd0,   8'd0,   8'd0  }},  // frame start mid-line
      '{8'd64,  8'd77,  8'd201, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd200, 8'd0,   8'd0,   1'b1, 1'b0, '{8'd0,   8'd0,   8'd0  }},  // frame start on odd row
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd1,   8'd0,   8'd0,   1'b0, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{8'd255, 8'd128, 8'd128, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b1, '{8'd0,   8'd0,   8'd0  }}
   };

   // Width settings after the directed table: odd, zero, one, oversized and
   // the all-ones code among them. Shrinking from 4096 to 2 lands mid-line
   // with the column already past the new width; 30 to 4 usually does too.
   phase_type width_phases [13] = '{
      '{13'd2,    50, 5 },
      '{13'd0,    40, 5 },
      '{13'd1,    30, 5 },
      '{13'd30,   65, 5 },
      '{13'd4,    40, 10},
      '{13'd8191, 40, 0 },
      '{13'd2,    30, 5 },
      '{13'd4097, 30, 0 },
      '{13'd6,    40, 5 },
      '{13'd5,    40, 5 },
      '{13'd16,   50, 5 },
      '{13'd4096, 20, 0 },
      '{13'd10,   40, 5 }
   };

   // ------------------------------------------------------------------
   // Response side: random ready gaps, bursts with none, and one long
   // hold-off that backs the pipe up into the request channel.
   // ------------------------------------------------------------------
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 47) == 0) begin
            sink_burst = ~sink_burst;
         end
         gap = sink_burst ? 0 : $urandom_range(0, 13);
         if (!held_off && pixels_checked >= 300) begin
            gap      = HOLD_CYCLES;
            held_off = 1'b1;
         end
         for (int k = 0; k < gap; k++) begin
            rsp_ch.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   // Response checker: in-order compare against the oldest prediction.
   always @(posedge clock) begin : check_response
      rgb_pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.red !== want.red) begin
               report_mismatch("red", rsp_ch.red, want.red);
            end
            if (rsp_ch.green !== want.green) begin
               report_mismatch("green", rsp_ch.green, want.green);
            end
            if (rsp_ch.blue !== want.blue) begin
               report_mismatch("blue", rsp_ch.blue, want.blue);
            end
            pixels_checked++;
         end
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_data_type w;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.luma        = '0;
      req_ch.cb_sample   = '0;
      req_ch.cr_sample   = '0;
      req_ch.frame_start = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset width of 1920: the first thousand pixels of an even row, so no
      // wrap may happen yet and the line buffer fills for later odd rows.
      // Partway in, requests stop until every response is back.
      send_pixel(pick_sample(), pick_sample(), pick_sample(), 1'b1, 1'b0, '0);
      run_pixels(699, 0);
      settle();
      run_pixels(300, 0);

      // Directed table at an odd programmed width.
      write_line_width(13'd3);
      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].luma, directed_rows[i].cb, directed_rows[i].cr,
                    directed_rows[i].fs, directed_rows[i].typed, directed_rows[i].rgb);
      end

      foreach (width_phases[i]) begin
         write_line_width(width_phases[i].width);
         run_pixels(width_phases[i].count, width_phases[i].fs_permille);
      end

      // A few random narrow widths to finish.
      for (int i = 0; i < 3; i++) begin
         w = cfg_data_type'($urandom_range(2, 40));
         write_line_width(w);
         run_pixels(50, 10);
      end

      settle();
      repeat (LATENCY + 4) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch("responses never returned", 0, expected_pixels.size());
      end

      $display("Sent %0d pixel requests and checked %0d RGB responses", pixels_sent,
               pixels_checked);
      $display("across %0d line-width settings, incl. reset, odd, zero and oversized",
               widths_used);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
